/* src/text_console_writer_assert.svh */
// assertion macros for the text console writer
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// property checked on clk, off during reset
`define TCW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// condition that must never hold
`define TCW_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* src/tcw_pkg.sv */
// shared types, request codes and cell helpers for the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;
	localparam int CELL_W = 16;

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [7:0] char_t;
	typedef logic [3:0] color_t;

	localparam logic [2:0] REQ_PUT_CUR   = 3'd0;
	localparam logic [2:0] REQ_PUT_POS   = 3'd1;
	localparam logic [2:0] REQ_SET_COLOR = 3'd2;
	localparam logic [2:0] REQ_REPAINT   = 3'd3;
	localparam logic [2:0] REQ_CLEAR     = 3'd4;
	localparam logic [2:0] REQ_READ      = 3'd5;

	localparam char_t CH_NEWLINE = 8'd10;
	localparam char_t CH_TAB     = 8'd9;
	localparam char_t CH_NUL     = 8'd0;
	localparam char_t CH_SPACE   = 8'd32;

	localparam logic [7:0] COLOR_MAX  = 8'd15;
	localparam color_t     FORE_RESET = 4'd15;
	localparam color_t     BACK_RESET = 4'd0;
	localparam logic       LAYER_BACK = 1'b0;

	typedef enum logic [1:0] {
		SW_INIT,
		SW_SCROLL,
		SW_REPAINT,
		SW_CLEAR
	} sweep_t;

	function automatic cell_t make_cell(color_t fg, color_t bg, char_t ch);
		return {bg, fg, ch};
	endfunction
endpackage

`default_nettype wire

/* src/text_console_writer.sv */
// text console writer top level: request sequencer around the screen cell memory
//
// One request is taken when start is high and busy is low; its result is shown on
// status, cell_word, cursor_row and cursor_col for the single cycle in which done is
// high, and the receiver has no way to hold it off. A tab writes TAB_WIDTH spaces, one
// cell at a time; set color does not touch the memory. Repaint and clear walk every
// cell, and each scroll walks every cell before the character that triggers it is placed.
// Their pace is set by the single write port of the cell memory, which takes one cell
// per cycle. After reset the memory is cleared in a pass over every cell, during which
// busy stays high.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_assert.svh"

module text_console_writer import tcw_pkg::*; #(
	parameter int ROWS = 25,
	parameter int COLS = 80,
	parameter int TAB_WIDTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [7:0]  row_pos,
	input  logic [7:0]  col_pos,
	input  logic [7:0]  color_value,
	input  logic        color_layer,
	output logic        done,
	output logic        status,
	output logic [15:0] cell_word,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col
);
	localparam int NCELLS = ROWS * COLS;
	localparam int AW = $clog2(NCELLS);
	localparam int RW = $clog2(ROWS + 1);
	localparam int CW = $clog2(COLS);
	localparam int TW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

	localparam logic [AW-1:0] LAST_ADDR = AW'(NCELLS - 1);
	localparam logic [AW-1:0] SHIFT_END = AW'(NCELLS - COLS);
	localparam logic [RW-1:0] ROW_END   = RW'(ROWS);
	localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLS - 1);
	localparam logic [TW-1:0] TAB_LAST  = TW'(TAB_WIDTH - 1);
	localparam logic [7:0]    ROWS_B    = 8'(ROWS);
	localparam logic [7:0]    COLS_B    = 8'(COLS);

	typedef enum logic [2:0] {
		S_SWEEP,
		S_DRAIN,
		S_IDLE,
		S_CHAR,
		S_READ
	} state_t;

	state_t          state_q;
	sweep_t          sweep_q;
	logic [AW-1:0]   cnt_q;
	logic            sw_vld_s1;
	logic [AW-1:0]   sw_addr_s1;
	logic [RW-1:0]   cur_row_q;
	logic [CW-1:0]   next_col_q;
	logic [RW-1:0]   wrk_row_q;
	logic [CW-1:0]   wrk_col_q;
	logic            restore_q;
	logic [TW-1:0]   tab_cnt_q;
	char_t           ch_q;
	color_t          fore_q;
	color_t          back_q;
	logic            done_q;
	logic            status_q;
	cell_t           word_q;

	logic            accept;
	logic            pos_ok;
	logic            color_ok;
	logic [AW-1:0]   pos_addr;
	logic [AW-1:0]   wrk_addr;
	char_t           put_ch;
	logic            scroll_now;
	logic            is_nl;
	logic            is_tab;
	logic            col_wrap;
	logic [CW-1:0]   adv_col;
	logic [RW-1:0]   adv_row;
	logic [RW-1:0]   nl_row;
	logic            char_we;
	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	cell_t           ram_wdata;
	cell_t           sweep_wdata;
	logic [AW-1:0]   ram_raddr;
	cell_t           ram_rdata;
	logic            done_set;
	logic            status_set;

	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign status     = status_q;
	assign cell_word  = word_q;
	assign cursor_row = 5'(cur_row_q);
	assign cursor_col = 7'(next_col_q);

	assign pos_ok   = (row_pos < ROWS_B) && (col_pos < COLS_B);
	assign color_ok = (color_value <= COLOR_MAX);
	assign pos_addr = AW'(32'(row_pos[RW-1:0]) * COLS + 32'(col_pos[CW-1:0]));
	assign wrk_addr = AW'(32'(wrk_row_q) * COLS + 32'(wrk_col_q));

	assign is_nl      = (ch_q == CH_NEWLINE);
	assign is_tab     = (ch_q == CH_TAB);
	assign put_ch     = is_tab ? CH_SPACE : ch_q;
	assign scroll_now = (wrk_row_q == ROW_END);
	assign col_wrap   = (wrk_col_q == COL_LAST);
	assign adv_col    = col_wrap ? '0 : CW'(wrk_col_q + CW'(1));
	assign nl_row     = RW'(wrk_row_q + RW'(1));
	assign adv_row    = col_wrap ? nl_row : wrk_row_q;
	assign char_we    = (state_q == S_CHAR) && !scroll_now && !is_nl;

	// result strobe and status for the beat that ends a request
	always_comb begin
		done_set   = 1'b0;
		status_set = 1'b0;
		unique case (state_q)
			S_DRAIN: done_set = (sweep_q == SW_REPAINT) || (sweep_q == SW_CLEAR);
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_PUT_CUR, REQ_CLEAR: begin
							done_set = 1'b0;
						end
						REQ_PUT_POS, REQ_READ: begin
							status_set = !pos_ok;
							done_set   = !pos_ok;
						end
						REQ_SET_COLOR, REQ_REPAINT: begin
							status_set = !color_ok;
							done_set   = !color_ok || (req_type == REQ_SET_COLOR);
						end
						default: begin
							done_set = 1'b1;
						end
					endcase
				end
			end
			S_READ:  done_set = 1'b1;
			S_CHAR:  done_set = !scroll_now && (is_nl || !is_tab || (tab_cnt_q == TAB_LAST));
			default: done_set = 1'b0;
		endcase
	end

	always_comb begin
		unique case (sweep_q)
			SW_INIT:    sweep_wdata = '0;
			SW_SCROLL:  sweep_wdata = (sw_addr_s1 < SHIFT_END)
				? make_cell(fore_q, back_q, ram_rdata[7:0])
				: make_cell(fore_q, back_q, CH_NUL);
			SW_REPAINT: sweep_wdata = make_cell(fore_q, back_q, ram_rdata[7:0]);
			SW_CLEAR:   sweep_wdata = make_cell(fore_q, back_q, CH_NUL);
			default:    sweep_wdata = '0;
		endcase
	end

	always_comb begin
		ram_we    = sw_vld_s1 || char_we;
		ram_waddr = sw_vld_s1 ? sw_addr_s1 : wrk_addr;
		ram_wdata = sw_vld_s1 ? sweep_wdata : make_cell(fore_q, back_q, put_ch);
		if (state_q == S_SWEEP) begin
			ram_raddr = (sweep_q == SW_SCROLL) ? AW'(32'(cnt_q) + COLS) : cnt_q;
		end else begin
			ram_raddr = pos_addr;
		end
	end

	tcw_cell_ram #(
		.DEPTH(NCELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_SWEEP;
			sweep_q    <= SW_INIT;
			cnt_q      <= '0;
			sw_vld_s1  <= 1'b0;
			sw_addr_s1 <= '0;
			cur_row_q  <= '0;
			next_col_q <= '0;
			wrk_row_q  <= '0;
			wrk_col_q  <= '0;
			restore_q  <= 1'b0;
			tab_cnt_q  <= '0;
			ch_q       <= '0;
			fore_q     <= FORE_RESET;
			back_q     <= BACK_RESET;
			done_q     <= 1'b0;
			status_q   <= 1'b0;
			word_q     <= '0;
		end else begin
			done_q     <= done_set;
			sw_vld_s1  <= (state_q == S_SWEEP);
			sw_addr_s1 <= cnt_q;
			unique case (state_q)
				S_SWEEP: begin
					if (cnt_q == LAST_ADDR) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= AW'(cnt_q + AW'(1));
					end
				end
				S_DRAIN: begin
					unique case (sweep_q)
						SW_INIT: begin
							state_q <= S_IDLE;
						end
						SW_SCROLL: begin
							wrk_row_q <= ROW_LAST;
							wrk_col_q <= '0;
							state_q   <= S_CHAR;
						end
						SW_REPAINT, SW_CLEAR: begin
							state_q <= S_IDLE;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_IDLE: begin
					if (accept) begin
						status_q  <= status_set;
						word_q    <= '0;
						ch_q      <= char_code;
						tab_cnt_q <= '0;
						cnt_q     <= '0;
						unique case (req_type)
							REQ_PUT_CUR: begin
								wrk_row_q <= cur_row_q;
								wrk_col_q <= next_col_q;
								restore_q <= 1'b0;
								state_q   <= S_CHAR;
							end
							REQ_PUT_POS: begin
								if (pos_ok) begin
									wrk_row_q <= row_pos[RW-1:0];
									wrk_col_q <= col_pos[CW-1:0];
									restore_q <= 1'b1;
									state_q   <= S_CHAR;
								end
							end
							REQ_SET_COLOR, REQ_REPAINT: begin
								if (color_ok) begin
									if (color_layer == LAYER_BACK) begin
										back_q <= color_value[3:0];
									end else begin
										fore_q <= color_value[3:0];
									end
									if (req_type == REQ_REPAINT) begin
										sweep_q <= SW_REPAINT;
										state_q <= S_SWEEP;
									end
								end
							end
							REQ_CLEAR: begin
								cur_row_q  <= '0;
								next_col_q <= '0;
								sweep_q    <= SW_CLEAR;
								state_q    <= S_SWEEP;
							end
							REQ_READ: begin
								if (pos_ok) begin
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_READ: begin
					word_q  <= ram_rdata;
					state_q <= S_IDLE;
				end
				S_CHAR: begin
					if (scroll_now) begin
						sweep_q <= SW_SCROLL;
						cnt_q   <= '0;
						state_q <= S_SWEEP;
					end else if (is_nl) begin
						wrk_row_q <= nl_row;
						wrk_col_q <= '0;
						if (!restore_q) begin
							cur_row_q  <= nl_row;
							next_col_q <= '0;
						end
						state_q <= S_IDLE;
					end else begin
						wrk_row_q <= adv_row;
						wrk_col_q <= adv_col;
						if (is_tab && (tab_cnt_q != TAB_LAST)) begin
							tab_cnt_q <= TW'(tab_cnt_q + TW'(1));
						end else begin
							if (!restore_q) begin
								cur_row_q  <= adv_row;
								next_col_q <= adv_col;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TCW_NEVER(a_idle_no_write, (state_q == S_IDLE) && ram_we, "cell write while idle")
	`TCW_ASSERT(a_put_goes_busy, (accept && (req_type == REQ_PUT_CUR)) |=> busy, "put not taken")
	`TCW_NEVER(a_done_when_busy, done && busy, "result shown while busy")
	`TCW_ASSERT(a_cursor_range, (cur_row_q <= ROW_END) && (next_col_q <= COL_LAST), "cursor range")
endmodule

`default_nettype wire

/* src/tcw_cell_ram.sv */
// screen cell memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram import tcw_pkg::*; #(
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  cell_t         wdata,
	input  logic [AW-1:0] raddr,
	output cell_t         rdata
);
	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

/* bench/tb.sv */
// testbench for text_console_writer: random and directed requests checked against a cell-level predictor
`timescale 1ns / 1ps

module tb;
	import tcw_pkg::*;

	localparam int ROWS      = 25;
	localparam int COLS      = 80;
	localparam int TAB_WIDTH = 4;
	localparam int NCELLS    = ROWS * COLS;

	localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
	localparam logic       LAYER_FORE    = ~LAYER_BACK;
	localparam logic       ST_DONE       = 1'b0;
	localparam logic       ST_INVALID    = 1'b1;

	localparam int LIVE_TARGET = 925;
	localparam int STALL_LIMIT = 6 * (2 * NCELLS + 2 * TAB_WIDTH + 250);
	localparam int TAIL_CYCLES = 32;

	typedef struct packed {
		logic [2:0] kind;
		char_t      ch;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] color;
		logic       layer;
	} req_t;

	typedef struct packed {
		logic       status;
		cell_t      word;
		logic [4:0] crow;
		logic [6:0] ccol;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  req_type = '0;
	logic [7:0]  char_code = '0;
	logic [7:0]  row_pos = '0;
	logic [7:0]  col_pos = '0;
	logic [7:0]  color_value = '0;
	logic        color_layer = 1'b0;
	logic        done;
	logic        status;
	logic [15:0] cell_word;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;

	text_console_writer #(
		.ROWS(ROWS),
		.COLS(COLS),
		.TAB_WIDTH(TAB_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.char_code(char_code),
		.row_pos(row_pos),
		.col_pos(col_pos),
		.color_value(color_value),
		.color_layer(color_layer),
		.done(done),
		.status(status),
		.cell_word(cell_word),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predicted console contents
	cell_t       screen_copy [NCELLS];
	int unsigned row_now = 0;
	int unsigned col_now = 0;
	color_t      back_col = BACK_RESET;
	color_t      fore_col = FORE_RESET;

	req_t   req_backlog [$];
	reply_t awaited_replies [$];
	int     live_items = 0;
	int     items_planned = 0;
	int     replies_seen = 0;
	int     mismatch_count = 0;
	int     stall_cycles = 0;
	int     gap_left = 0;
	int     quiet_left = 0;

	function automatic cell_t paint(char_t ch);
		return {back_col, fore_col, ch};
	endfunction

	function automatic void shift_up();
		for (int i = 0; i + COLS < NCELLS; i++)
			screen_copy[i] = paint(screen_copy[i + COLS][7:0]);
		for (int i = NCELLS - COLS; i < NCELLS; i++)
			screen_copy[i] = paint(CH_NUL);
		row_now = ROWS - 1;
		col_now = 0;
	endfunction

	function automatic void place_plain(char_t ch);
		if (row_now >= ROWS)
			shift_up();
		if (col_now >= COLS)
			col_now = 0;
		screen_copy[row_now * COLS + col_now] = paint(ch);
		col_now++;
		if (col_now >= COLS) begin
			col_now = 0;
			row_now++;
		end
	endfunction

	function automatic void place_char(char_t ch);
		if (row_now >= ROWS)
			shift_up();
		if (ch == CH_NEWLINE) begin
			col_now = 0;
			row_now++;
		end else if (ch == CH_TAB) begin
			for (int i = 0; i < TAB_WIDTH; i++)
				place_plain(CH_SPACE);
		end else begin
			place_plain(ch);
		end
	endfunction

	function automatic reply_t console_step(req_t q);
		reply_t      r;
		int unsigned keep_row;
		int unsigned keep_col;
		logic        pos_ok;
		r = '0;
		r.status = ST_DONE;
		pos_ok = (q.row < ROWS) && (q.col < COLS);
		case (q.kind)
			REQ_PUT_CUR: place_char(q.ch);
			REQ_PUT_POS: begin
				if (pos_ok) begin
					keep_row = row_now;
					keep_col = col_now;
					row_now = q.row;
					col_now = q.col;
					place_char(q.ch);
					row_now = keep_row;
					col_now = keep_col;
				end else begin
					r.status = ST_INVALID;
				end
			end
			REQ_SET_COLOR, REQ_REPAINT: begin
				if (q.color > COLOR_MAX) begin
					r.status = ST_INVALID;
				end else begin
					if (q.layer == LAYER_BACK)
						back_col = q.color[3:0];
					else
						fore_col = q.color[3:0];
					if (q.kind == REQ_REPAINT)
						for (int i = 0; i < NCELLS; i++)
							screen_copy[i] = paint(screen_copy[i][7:0]);
				end
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NCELLS; i++)
					screen_copy[i] = paint(CH_NUL);
				row_now = 0;
				col_now = 0;
			end
			REQ_READ: begin
				if (pos_ok)
					r.word = screen_copy[q.row * COLS + q.col];
				else
					r.status = ST_INVALID;
			end
			default: ;
		endcase
		r.crow = row_now[4:0];
		r.ccol = col_now[6:0];
		return r;
	endfunction

	// stimulus helpers
	function automatic req_t pick(logic [2:0] kind);
		req_t q;
		q.kind  = kind;
		q.ch    = 8'($urandom_range(0, 255));
		q.row   = 8'($urandom_range(0, 255));
		q.col   = 8'($urandom_range(0, 255));
		q.color = 8'($urandom_range(0, 255));
		q.layer = 1'($urandom_range(0, 1));
		return q;
	endfunction

	function automatic char_t text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return CH_NEWLINE;
		else if (r < 11)
			return CH_TAB;
		else if (r < 16)
			return char_t'($urandom_range(0, 255));
		return char_t'($urandom_range(32, 126));
	endfunction

	function automatic logic [7:0] some_color();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(0, 15));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic plan(req_t q);
		req_backlog.push_back(q);
		if (q.kind <= REQ_READ)
			live_items++;
	endtask

	task automatic plan_at(logic [2:0] kind, logic [7:0] row, logic [7:0] col, char_t ch);
		req_t q;
		q = pick(kind);
		q.row = row;
		q.col = col;
		q.ch = ch;
		plan(q);
	endtask

	task automatic plan_color(logic [2:0] kind, logic [7:0] color, logic layer);
		req_t q;
		q = pick(kind);
		q.color = color;
		q.layer = layer;
		plan(q);
	endtask

	task automatic plan_text(int n);
		req_t q;
		for (int i = 0; i < n; i++) begin
			q = pick(REQ_PUT_CUR);
			q.ch = text_char();
			plan(q);
		end
	endtask

	task automatic plan_valid_reads(int n);
		for (int i = 0; i < n; i++)
			plan_at(REQ_READ, 8'($urandom_range(0, ROWS - 1)),
				8'($urandom_range(0, COLS - 1)), 8'($urandom_range(0, 255)));
	endtask

	task automatic plan_single();
		req_t q;
		int   r;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			q = pick(REQ_PUT_CUR);
			r = $urandom_range(0, 99);
			if (r < 10)
				q.ch = CH_NEWLINE;
			else if (r < 18)
				q.ch = CH_TAB;
			plan(q);
		end else if (r < 45) begin
			q = pick(REQ_PUT_POS);
			if ($urandom_range(0, 99) < 85) begin
				q.row = 8'($urandom_range(0, ROWS - 1));
				q.col = 8'($urandom_range(0, COLS - 1));
			end
			if ($urandom_range(0, 99) < 15)
				q.ch = ($urandom_range(0, 1) != 0) ? CH_TAB : CH_NEWLINE;
			plan(q);
		end else if (r < 60) begin
			plan_color(REQ_SET_COLOR, some_color(), 1'($urandom_range(0, 1)));
		end else if (r < 63) begin
			plan_color(REQ_REPAINT, some_color(), 1'($urandom_range(0, 1)));
		end else if (r < 65) begin
			plan(pick(REQ_CLEAR));
		end else if (r < 95) begin
			q = pick(REQ_READ);
			if ($urandom_range(0, 99) < 90) begin
				q.row = 8'($urandom_range(0, ROWS - 1));
				q.col = 8'($urandom_range(0, COLS - 1));
			end
			plan(q);
		end else begin
			plan(pick(($urandom_range(0, 1) != 0) ? REQ_UNUSED_HI : REQ_UNUSED_LO));
		end
	endtask

	// a few long gaps, mostly short ones, and stretches with none
	function automatic int pick_gap();
		int r;
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			quiet_left = $urandom_range(20, 80);
			return 0;
		end else if (r < 40) begin
			return 0;
		end else if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 96) begin
			return $urandom_range(4, 15);
		end
		return $urandom_range(40, 200);
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		int   wait_n;
		req_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (!start || !busy) begin
			wait_n = gap_left;
			if (start)
				wait_n = pick_gap();
			if (wait_n == 0 && req_backlog.size() != 0) begin
				nxt = req_backlog.pop_front();
				start <= 1'b1;
				req_type <= nxt.kind;
				char_code <= nxt.ch;
				row_pos <= nxt.row;
				col_pos <= nxt.col;
				color_value <= nxt.color;
				color_layer <= nxt.layer;
				gap_left <= 0;
			end else begin
				start <= 1'b0;
				gap_left <= (wait_n > 0) ? wait_n - 1 : 0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		reply_t want;
		req_t   seen;
		if (arst_n) begin
			if (done) begin
				if (awaited_replies.size() == 0) begin
					$error("result beat with no pending request");
					mismatch_count++;
				end else begin
					want = awaited_replies.pop_front();
					replies_seen++;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatch_count++;
					end
					if (cell_word !== want.word) begin
						$error("cell_word: expected %h, got %h", want.word, cell_word);
						mismatch_count++;
					end
					if (cursor_row !== want.crow) begin
						$error("cursor_row: expected %0d, got %0d", want.crow, cursor_row);
						mismatch_count++;
					end
					if (cursor_col !== want.ccol) begin
						$error("cursor_col: expected %0d, got %0d", want.ccol, cursor_col);
						mismatch_count++;
					end
				end
			end
			if (start && !busy) begin
				seen = '{req_type, char_code, row_pos, col_pos, color_value, color_layer};
				awaited_replies.push_back(console_step(seen));
			end
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("text_console_writer verification failed");
		$finish;
	end

	initial begin : stimulus
		req_t q;
		int   r;
		for (int i = 0; i < NCELLS; i++)
			screen_copy[i] = '0;

		// directed part
		plan_at(REQ_READ, 8'd0, 8'd0, 8'h5A);
		plan_at(REQ_PUT_CUR, 8'hFF, 8'hFF, 8'h41);
		plan_at(REQ_PUT_CUR, 8'h00, 8'h00, 8'hFF);
		plan_at(REQ_PUT_CUR, 8'h80, 8'h80, CH_NUL);
		plan_at(REQ_PUT_CUR, 8'h55, 8'hAA, CH_NEWLINE);
		plan_at(REQ_PUT_CUR, 8'hAA, 8'h55, CH_TAB);
		plan_at(REQ_PUT_POS, 8'(ROWS - 1), 8'(COLS - 1), 8'h7E);
		plan_at(REQ_PUT_POS, 8'(ROWS), 8'd0, 8'h31);
		plan_at(REQ_PUT_POS, 8'd0, 8'(COLS), 8'h32);
		plan_at(REQ_PUT_POS, 8'hFF, 8'hFF, 8'h33);
		plan_at(REQ_PUT_POS, 8'(ROWS - 1), 8'(COLS - 2), CH_TAB);
		plan_at(REQ_PUT_POS, 8'd3, 8'd5, CH_NEWLINE);
		plan_at(REQ_PUT_POS, 8'd0, 8'(COLS - 1), 8'hAA);
		plan_color(REQ_SET_COLOR, 8'd0, LAYER_FORE);
		plan_color(REQ_SET_COLOR, {4'd0, COLOR_MAX[3:0]}, LAYER_BACK);
		plan_color(REQ_SET_COLOR, COLOR_MAX + 8'd1, LAYER_FORE);
		plan_color(REQ_SET_COLOR, 8'hFF, LAYER_BACK);
		plan_color(REQ_REPAINT, 8'd8, LAYER_FORE);
		plan_color(REQ_REPAINT, 8'd200, LAYER_BACK);
		plan_at(REQ_READ, 8'(ROWS - 1), 8'(COLS - 1), 8'h00);
		plan_at(REQ_READ, 8'(ROWS), 8'd0, 8'h00);
		plan_at(REQ_READ, 8'd0, 8'(COLS), 8'h00);
		plan(pick(REQ_UNUSED_LO));
		plan(pick(REQ_UNUSED_HI));
		plan(pick(REQ_CLEAR));

		// random part
		while (live_items < LIVE_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				plan_single();
			end else if (r < 85) begin
				plan_text($urandom_range(5, 40));
			end else if (r < 92) begin
				// fill to the bottom row so that the text scrolls
				plan(pick(REQ_CLEAR));
				for (int i = $urandom_range(22, 27); i > 0; i--) begin
					if ($urandom_range(0, 99) < 30)
						plan_text(1);
					q = pick(REQ_PUT_CUR);
					q.ch = CH_NEWLINE;
					plan(q);
				end
				plan_text($urandom_range(0, 120));
				plan_at(REQ_READ, 8'(ROWS - 2), 8'($urandom_range(0, COLS - 1)), 8'h00);
				plan_at(REQ_READ, 8'(ROWS - 1), 8'($urandom_range(0, COLS - 1)), 8'h00);
			end else begin
				plan_color(REQ_SET_COLOR, 8'($urandom_range(0, 15)), LAYER_FORE);
				plan_color(REQ_SET_COLOR, 8'($urandom_range(0, 15)), LAYER_BACK);
				plan_color(REQ_REPAINT, some_color(), 1'($urandom_range(0, 1)));
				plan_valid_reads($urandom_range(2, 4));
			end
		end
		items_planned = req_backlog.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (replies_seen < items_planned)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_replies.size() != 0) begin
			$error("%0d expected results never arrived", awaited_replies.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("text_console_writer verification clean");
		else
			$display("text_console_writer verification failed");
		$finish;
	end
endmodule
